// ----- rtl/eul2q_pkg.sv -----
// ----------------------------------------------------------------------------
// eul2q_pkg: shared types and constants for the euler to quaternion block
// word layouts, cordic lane type, arctangent table and the rounded q30 multiply
// ----------------------------------------------------------------------------
package eul2q_pkg;

   localparam int ANGLE_W   = 16;   // input angle, degrees * 64
   localparam int QUAT_W    = 16;   // output component
   localparam int XY_W      = 33;   // cordic x/y and q30 values with headroom
   localparam int Z_W       = 32;   // residual angle, degrees * 2^23
   localparam int PROD_W    = 2 * XY_W;
   localparam int TABLE_LEN = 24;

   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = 16'sd23040;
   localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd11520;
   localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 16'sd23040;
   localparam logic signed [XY_W-1:0]    GAIN_Q30     = 33'sd652032874;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } angles_req_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } quat_rsp_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } cordic_lane_type;

   typedef struct packed {
      logic signed [XY_W-1:0] sin;
      logic signed [XY_W-1:0] cos;
   } sincos_type;

   // atan(2^-i) in degrees * 2^23
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:       val = 32'sd377487360;
         1:       val = 32'sd222843801;
         2:       val = 32'sd117744544;
         3:       val = 32'sd59768969;
         4:       val = 32'sd30000467;
         5:       val = 32'sd15014858;
         6:       val = 32'sd7509261;
         7:       val = 32'sd3754860;
         8:       val = 32'sd1877459;
         9:       val = 32'sd938733;
         10:      val = 32'sd469367;
         11:      val = 32'sd234683;
         12:      val = 32'sd117342;
         13:      val = 32'sd58671;
         14:      val = 32'sd29335;
         15:      val = 32'sd14668;
         16:      val = 32'sd7334;
         17:      val = 32'sd3667;
         18:      val = 32'sd1833;
         19:      val = 32'sd917;
         20:      val = 32'sd458;
         21:      val = 32'sd229;
         22:      val = 32'sd115;
         23:      val = 32'sd57;
         default: val = '0;
      endcase
      return val;
   endfunction

   // round(a*b / 2^30), floor after adding half
   function automatic logic signed [XY_W-1:0] qmul(input logic signed [XY_W-1:0] a,
                                                   input logic signed [XY_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b);
      p = p + (PROD_W'(1) <<< 29);
      return p[XY_W+29:30];
   endfunction

endpackage

// ----- rtl/eul2q_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// eul2q_cordic_cell: one rotation-mode cordic iteration
// shifts by its fixed stage index and registers the rotated lane
// ----------------------------------------------------------------------------
module eul2q_cordic_cell import eul2q_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  cordic_lane_type lane_i,
   output cordic_lane_type lane_o
);

   cordic_lane_type lane_in;
   cordic_lane_type lane_ff;

   localparam logic signed [Z_W-1:0] ATAN = atan_entry(STAGE);

   always_comb begin
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      xs = lane_i.x >>> STAGE;
      ys = lane_i.y >>> STAGE;
      lane_in.flip = lane_i.flip;
      if (!lane_i.z[Z_W-1]) begin
         lane_in.x = lane_i.x - ys;
         lane_in.y = lane_i.y + xs;
         lane_in.z = lane_i.z - ATAN;
      end else begin
         lane_in.x = lane_i.x + ys;
         lane_in.y = lane_i.y - xs;
         lane_in.z = lane_i.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;

endmodule

// ----- rtl/eul2q_cordic.sv -----
// ----------------------------------------------------------------------------
// eul2q_cordic: half-angle sine and cosine
// clamps and folds the angle, runs it down a chain of cordic cells, unfolds
// ----------------------------------------------------------------------------
module eul2q_cordic import eul2q_pkg::*; #(
   parameter int NUM_STAGES = 16
) (
   input  logic                      clock,
   input  logic signed [ANGLE_W-1:0] angle,
   output sincos_type                result
);

   cordic_lane_type prep_in;
   cordic_lane_type prep_ff;
   cordic_lane_type chain [0:NUM_STAGES];
   sincos_type      result_in;
   sincos_type      result_ff;

   // raw angle read as 1/128 degree, i.e. the half angle
   always_comb begin
      logic signed [ANGLE_W-1:0] a;
      a = angle;
      if (a > ANGLE_LIMIT) begin
         a = ANGLE_LIMIT;
      end
      if (a < -ANGLE_LIMIT) begin
         a = -ANGLE_LIMIT;
      end
      prep_in.flip = 1'b0;
      if (a > QUARTER_TURN) begin
         a = a - HALF_TURN;
         prep_in.flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
         a = a + HALF_TURN;
         prep_in.flip = 1'b1;
      end
      prep_in.x = GAIN_Q30;
      prep_in.y = '0;
      prep_in.z = $signed({a, 16'h0000});
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   assign chain[0] = prep_ff;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
      eul2q_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock  (clock),
         .lane_i (chain[i]),
         .lane_o (chain[i+1])
      );
   end

   // undo the half-turn fold
   always_comb begin
      if (chain[NUM_STAGES].flip) begin
         result_in.sin = -chain[NUM_STAGES].y;
         result_in.cos = -chain[NUM_STAGES].x;
      end else begin
         result_in.sin = chain[NUM_STAGES].y;
         result_in.cos = chain[NUM_STAGES].x;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ----- rtl/eul2q_combine.sv -----
// ----------------------------------------------------------------------------
// eul2q_combine: zyx products and output scaling
// pair products, triple products, then sum, round and saturate
// ----------------------------------------------------------------------------
module eul2q_combine import eul2q_pkg::*; #(
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic         clock,
   input  sincos_type   roll,
   input  sincos_type   pitch,
   input  sincos_type   yaw,
   output quat_rsp_type quat
);

   localparam int FRAC  = (OUT_FRAC_BITS < 30) ? OUT_FRAC_BITS : 30;
   localparam int SHIFT = 30 - FRAC;
   localparam int SUM_W = XY_W + 2;
   localparam logic [SUM_W-1:0] ROUND = (SUM_W'(1) << SHIFT) >> 1;
   localparam logic signed [SUM_W-1:0] OUT_HI =
      (FRAC >= 15) ? SUM_W'(32767) : (SUM_W'(1) <<< FRAC) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] OUT_LO =
      (FRAC >= 15) ? -SUM_W'(32768) : -(SUM_W'(1) <<< FRAC);

   // first level: pair products, angles passed along
   logic signed [XY_W-1:0] cpcy_ff, spsy_ff, crsp_ff, srcp_ff, crcp_ff, srsp_ff;
   logic signed [XY_W-1:0] cr_ff, sr_ff, cy_ff, sy_ff;

   always_ff @(posedge clock) begin
      cpcy_ff <= qmul(pitch.cos, yaw.cos);
      spsy_ff <= qmul(pitch.sin, yaw.sin);
      crsp_ff <= qmul(roll.cos, pitch.sin);
      srcp_ff <= qmul(roll.sin, pitch.cos);
      crcp_ff <= qmul(roll.cos, pitch.cos);
      srsp_ff <= qmul(roll.sin, pitch.sin);
      cr_ff   <= roll.cos;
      sr_ff   <= roll.sin;
      cy_ff   <= yaw.cos;
      sy_ff   <= yaw.sin;
   end

   // second level: triple products
   logic signed [XY_W-1:0] w1_ff, w2_ff, x1_ff, x2_ff, y1_ff, y2_ff, z1_ff, z2_ff;

   always_ff @(posedge clock) begin
      w1_ff <= qmul(cr_ff, cpcy_ff);
      w2_ff <= qmul(sr_ff, spsy_ff);
      x1_ff <= qmul(sr_ff, cpcy_ff);
      x2_ff <= qmul(cr_ff, spsy_ff);
      y1_ff <= qmul(crsp_ff, cy_ff);
      y2_ff <= qmul(srcp_ff, sy_ff);
      z1_ff <= qmul(crcp_ff, sy_ff);
      z2_ff <= qmul(srsp_ff, cy_ff);
   end

   function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + $signed(ROUND)) >>> SHIFT;
      if (r > OUT_HI) begin
         r = OUT_HI;
      end
      if (r < OUT_LO) begin
         r = OUT_LO;
      end
      return r[QUAT_W-1:0];
   endfunction

   quat_rsp_type quat_in;
   quat_rsp_type quat_ff;

   always_comb begin
      quat_in.quat_w = to_out(SUM_W'(w1_ff) + SUM_W'(w2_ff));
      quat_in.quat_x = to_out(SUM_W'(x1_ff) - SUM_W'(x2_ff));
      quat_in.quat_y = to_out(SUM_W'(y1_ff) + SUM_W'(y2_ff));
      quat_in.quat_z = to_out(SUM_W'(z1_ff) - SUM_W'(z2_ff));
   end

   always_ff @(posedge clock) begin
      quat_ff <= quat_in;
   end

   assign quat = quat_ff;

endmodule

// ----- rtl/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll/pitch/yaw to unit rotation quaternion, zyx order
// pipelined cordic sine/cosine of the half angles and fixed-point products
// ----------------------------------------------------------------------------
// A word of three angles (degrees * 64, clamped to +-360 degrees) is taken on
// any cycle where start is high and busy is low; busy is low except during
// reset, so one word can enter every clock. Its quaternion (w, x, y, z,
// Q1.OUT_FRAC_BITS, saturated just below +1) comes out on rsp_data for exactly
// one cycle with rsp_strobe high, in input order. The word is registered
// after angle folding, after each cell of the cordic chain (one cell per
// iteration), after sign restore, after the pair products, after the triple
// products and after the rounded, saturated sum. The receiver cannot stall
// the pipeline, so it must take every strobed word. No state is kept between
// words.
module euler_to_quaternion import eul2q_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  angles_req_type req_data,
   output logic           rsp_strobe,
   output quat_rsp_type   rsp_data
);

   // the arctangent table bounds the usable iteration count
   localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int LATENCY    = NUM_STAGES + 5;

   sincos_type roll_sc;
   sincos_type pitch_sc;
   sincos_type yaw_sc;

   logic [LATENCY-1:0] valid_in;
   logic [LATENCY-1:0] valid_ff;

   // only held off while reset clears the valid pipeline
   assign busy = reset;

   // three identical cordic chains, one per axis
   eul2q_cordic #(
      .NUM_STAGES (NUM_STAGES)
   ) u_roll (
      .clock  (clock),
      .angle  (req_data.roll_angle),
      .result (roll_sc)
   );

   eul2q_cordic #(
      .NUM_STAGES (NUM_STAGES)
   ) u_pitch (
      .clock  (clock),
      .angle  (req_data.pitch_angle),
      .result (pitch_sc)
   );

   eul2q_cordic #(
      .NUM_STAGES (NUM_STAGES)
   ) u_yaw (
      .clock  (clock),
      .angle  (req_data.yaw_angle),
      .result (yaw_sc)
   );

   // products, sum, round and saturate
   eul2q_combine #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_combine (
      .clock (clock),
      .roll  (roll_sc),
      .pitch (pitch_sc),
      .yaw   (yaw_sc),
      .quat  (rsp_data)
   );

   // valid flag travels alongside the data pipeline
   always_comb begin
      valid_in = {valid_ff[LATENCY-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe = valid_ff[LATENCY-1];

endmodule
